// ===== hdl/assert_macros.svh =====
// assertion helpers included by the cipher top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/trsc_pkg.sv =====
package trsc_pkg;

  localparam int LETTER_W    = 5;
  localparam int SEL_W       = 2;
  localparam int ROTOR_COUNT = 3;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_ENC  = 2'd1,
    FUNC_DEC  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [1:0] CFG_START_ONE   = 2'd0;
  localparam logic [1:0] CFG_START_TWO   = 2'd1;
  localparam logic [1:0] CFG_START_THREE = 2'd2;

  // one item travelling down the rotor pipeline
  typedef struct packed {
    func_t                                 op;
    logic [SEL_W-1:0]                      sel;
    logic [LETTER_W-1:0]                   idx;
    logic [LETTER_W-1:0]                   c;
    logic [ROTOR_COUNT-1:0][LETTER_W-1:0]  off;
  } item_t;

  // rotor rotations and letter count
  typedef struct packed {
    logic [ROTOR_COUNT-1:0][LETTER_W-1:0]  off;
    logic [LETTER_W-1:0]                   pos_lo;
    logic [LETTER_W-1:0]                   pos_hi;
  } odo_t;

  // (a + b) mod n, both operands below n
  function automatic logic [LETTER_W-1:0] add_mod(input logic [LETTER_W-1:0] a,
                                                  input logic [LETTER_W-1:0] b,
                                                  input int unsigned n);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LETTER_W+1)'(n)) s = s - (LETTER_W+1)'(n);
    return s[LETTER_W-1:0];
  endfunction

  // (a - b) mod n, both operands below n
  function automatic logic [LETTER_W-1:0] sub_mod(input logic [LETTER_W-1:0] a,
                                                  input logic [LETTER_W-1:0] b,
                                                  input int unsigned n);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + (LETTER_W+1)'(n) - {1'b0, b};
    if (s >= (LETTER_W+1)'(n)) s = s - (LETTER_W+1)'(n);
    return s[LETTER_W-1:0];
  endfunction

  // v mod n by restoring compare-subtract, one step per bit of v
  function automatic logic [LETTER_W-1:0] reduce(input logic [LETTER_W-1:0] v,
                                                 input int unsigned n);
    logic [2*LETTER_W-1:0] r;
    logic [2*LETTER_W-1:0] m;
    r = {{LETTER_W{1'b0}}, v};
    for (int s = LETTER_W - 1; s >= 0; s--) begin
      m = (2*LETTER_W)'(n << s);
      if (r >= m) r = r - m;
    end
    return r[LETTER_W-1:0];
  endfunction

endpackage

// ===== hdl/trsc_odometer.sv =====
module trsc_odometer #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              cfg_we,
  input  logic [1:0]                                        cfg_index,
  input  logic [trsc_pkg::LETTER_W-1:0]                     cfg_data,
  input  logic                                              step,
  input  logic                                              restart,
  output logic [trsc_pkg::ROTOR_COUNT-1:0][trsc_pkg::LETTER_W-1:0] use_off,
  output trsc_pkg::odo_t                                    state
);

  logic [trsc_pkg::ROTOR_COUNT-1:0][trsc_pkg::LETTER_W-1:0] start;
  trsc_pkg::odo_t cur;
  trsc_pkg::odo_t state_next;

  // start values kept already reduced
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trsc_pkg::CFG_START_ONE:   start[0] <= trsc_pkg::reduce(cfg_data, ALPHABET_SIZE);
        trsc_pkg::CFG_START_TWO:   start[1] <= trsc_pkg::reduce(cfg_data, ALPHABET_SIZE);
        trsc_pkg::CFG_START_THREE: start[2] <= trsc_pkg::reduce(cfg_data, ALPHABET_SIZE);
        default: ;
      endcase
    end
  end

  always_comb begin
    cur = state;
    if (restart) begin
      cur.off    = start;
      cur.pos_lo = '0;
      cur.pos_hi = '0;
    end
    state_next        = cur;
    state_next.off[0] = trsc_pkg::add_mod(cur.off[0], 5'd1, ALPHABET_SIZE);
    state_next.pos_lo = trsc_pkg::add_mod(cur.pos_lo, 5'd1, ALPHABET_SIZE);
    if (state_next.pos_lo == '0) begin
      state_next.off[1] = trsc_pkg::add_mod(cur.off[1], 5'd1, ALPHABET_SIZE);
      state_next.pos_hi = trsc_pkg::add_mod(cur.pos_hi, 5'd1, ALPHABET_SIZE);
      if (state_next.pos_hi == '0) begin
        state_next.off[2] = trsc_pkg::add_mod(cur.off[2], 5'd1, ALPHABET_SIZE);
      end
    end
  end

  assign use_off = cur.off;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/trsc_rotor_stage.sv =====
module trsc_rotor_stage #(
  parameter int ALPHABET_SIZE = 26,
  parameter int STAGE         = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  trsc_pkg::item_t up_item,
  output logic            dn_valid,
  input  logic            dn_ready,
  output trsc_pkg::item_t dn_item
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [trsc_pkg::SEL_W-1:0] FWD_SEL = trsc_pkg::SEL_W'(STAGE);
  localparam int INV_ROTOR = trsc_pkg::ROTOR_COUNT - 1 - STAGE;
  localparam logic [trsc_pkg::SEL_W-1:0] INV_SEL = trsc_pkg::SEL_W'(INV_ROTOR);

  // forward table of this rotor, inverse table of the mirrored rotor
  logic [trsc_pkg::LETTER_W-1:0] fwd_mem [ALPHABET_SIZE];
  logic [trsc_pkg::LETTER_W-1:0] inv_mem [ALPHABET_SIZE];

  logic                          vld;
  trsc_pkg::item_t               item_q;
  logic [trsc_pkg::LETTER_W-1:0] fwd_q;
  logic [trsc_pkg::LETTER_W-1:0] inv_q;
  logic [trsc_pkg::LETTER_W-1:0] fwd_addr;
  logic                          take;
  logic                          is_load;

  assign up_ready = !vld || dn_ready;
  assign take     = up_valid && up_ready;
  assign is_load  = (up_item.op == trsc_pkg::FUNC_LOAD);
  assign fwd_addr = trsc_pkg::add_mod(up_item.c, up_item.off[STAGE], ALPHABET_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  // read and write in item order, so loads and lookups never pass each other
  always_ff @(posedge clk) begin
    if (take) begin
      item_q <= up_item;
      fwd_q  <= fwd_mem[fwd_addr[AW-1:0]];
      inv_q  <= inv_mem[up_item.c[AW-1:0]];
      if (is_load && up_item.sel == FWD_SEL) begin
        fwd_mem[up_item.idx[AW-1:0]] <= up_item.c;
      end
      if (is_load && up_item.sel == INV_SEL) begin
        inv_mem[up_item.c[AW-1:0]] <= up_item.idx;
      end
    end
  end

  always_comb begin
    dn_item = item_q;
    case (item_q.op)
      trsc_pkg::FUNC_ENC: dn_item.c = fwd_q;
      trsc_pkg::FUNC_DEC: dn_item.c = trsc_pkg::sub_mod(inv_q, item_q.off[INV_ROTOR],
                                                        ALPHABET_SIZE);
      default:            dn_item.c = item_q.c;
    endcase
  end

  assign dn_valid = vld;

endmodule

// ===== hdl/three_rotor_stepping_cipher.sv =====
// three-rotor stepping substitution cipher, no reflector
// input channel (in_valid/in_ready): one beat per item; func selects a
//   wiring load (rotor_sel, entry_index, letter), encipher or decipher;
//   restart on a cipher beat reloads the start rotations first
// output channel (out_valid/out_ready): one out_letter beat per cipher
//   item, in order; loads, bad loads and func 3 give no beat
// config port: cfg_we writes start_offset_one/two/three by cfg_index
// throughput: one item per cycle while the receiver takes each cipher beat,
//   wiring loads included; a cipher item passes the input register,
//   then three rotor stages, before its result shows on out_letter
// each rotor stage owns a forward and an inverse table with a registered
//   read; loads ride the same pipe and write at the stage that
//   owns the table, so lookups and loads stay in order
// reset clears rotations, letter count, start values and pipe valids;
//   the wiring tables stay undefined until loaded
// a stalled receiver holds the last stage; earlier stages keep filling
//   bubbles, and in_ready drops only once every stage is full
module three_rotor_stepping_cipher #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [trsc_pkg::LETTER_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic                          restart,
  input  logic [trsc_pkg::SEL_W-1:0]    rotor_sel,
  input  logic [trsc_pkg::LETTER_W-1:0] entry_index,
  input  logic [trsc_pkg::LETTER_W-1:0] letter,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trsc_pkg::LETTER_W-1:0] out_letter
);

  `include "assert_macros.svh"

  // alphabet size one bit wider, so a full 32-letter alphabet still compares
  localparam logic [trsc_pkg::LETTER_W:0] ABC_LIMIT = (trsc_pkg::LETTER_W+1)'(ALPHABET_SIZE);

  trsc_pkg::func_t op_in;
  logic            in_beat;
  logic            is_cipher;
  logic            load_ok;
  logic            cipher_beat;
  logic [trsc_pkg::ROTOR_COUNT-1:0][trsc_pkg::LETTER_W-1:0] use_off;
  trsc_pkg::odo_t  odo_state;

  // input register
  logic            s0_valid;
  trsc_pkg::item_t s0_item;
  trsc_pkg::item_t s0_item_next;

  // stage links
  logic            st0_ready;
  logic            st0_valid;
  trsc_pkg::item_t st0_item;
  logic            st1_ready;
  logic            st1_valid;
  trsc_pkg::item_t st1_item;
  logic            st2_ready;
  logic            st2_valid;
  trsc_pkg::item_t st2_item;
  logic            st2_cipher;

  assign op_in     = trsc_pkg::func_t'(func);
  assign in_ready  = !s0_valid || st0_ready;
  assign in_beat   = in_valid && in_ready;
  assign is_cipher = (op_in == trsc_pkg::FUNC_ENC) || (op_in == trsc_pkg::FUNC_DEC);
  // out-of-range loads are dropped here and never reach the tables
  assign load_ok   = (op_in == trsc_pkg::FUNC_LOAD)
                  && (rotor_sel < trsc_pkg::SEL_W'(trsc_pkg::ROTOR_COUNT))
                  && ({1'b0, entry_index} < ABC_LIMIT)
                  && ({1'b0, letter} < ABC_LIMIT);
  assign cipher_beat = in_beat && is_cipher;

  // rotations and letter count, stepped once per cipher beat
  trsc_odometer #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_odometer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (cipher_beat),
    .restart   (restart),
    .use_off   (use_off),
    .state     (odo_state)
  );

  always_comb begin
    s0_item_next.op  = op_in;
    s0_item_next.sel = rotor_sel;
    s0_item_next.idx = entry_index;
    s0_item_next.off = use_off;
    // cipher letters are folded into the alphabet, load letters are in range
    s0_item_next.c   = is_cipher ? trsc_pkg::reduce(letter, ALPHABET_SIZE) : letter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid && (is_cipher || load_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s0_item <= s0_item_next;
    end
  end

  trsc_rotor_stage #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .STAGE(0)
  ) u_stage0 (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s0_valid),
    .up_ready (st0_ready),
    .up_item  (s0_item),
    .dn_valid (st0_valid),
    .dn_ready (st1_ready),
    .dn_item  (st0_item)
  );

  trsc_rotor_stage #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .STAGE(1)
  ) u_stage1 (
    .clk      (clk),
    .rst      (rst),
    .up_valid (st0_valid),
    .up_ready (st1_ready),
    .up_item  (st0_item),
    .dn_valid (st1_valid),
    .dn_ready (st2_ready),
    .dn_item  (st1_item)
  );

  trsc_rotor_stage #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .STAGE(2)
  ) u_stage2 (
    .clk      (clk),
    .rst      (rst),
    .up_valid (st1_valid),
    .up_ready (st2_ready),
    .up_item  (st1_item),
    .dn_valid (st2_valid),
    .dn_ready (out_ready || !st2_cipher),
    .dn_item  (st2_item)
  );

  // loads leave the pipe at the last stage without a beat
  assign st2_cipher = (st2_item.op == trsc_pkg::FUNC_ENC)
                   || (st2_item.op == trsc_pkg::FUNC_DEC);
  assign out_valid  = st2_valid && st2_cipher;
  assign out_letter = st2_item.c;

  `ASSERT_NEXT(a_s0_hold, clk, rst, s0_valid && !st0_ready,
               s0_valid && $stable(s0_item), "input register lost a waiting item")
  `ASSERT_HOLDS(a_load_range, clk, rst, s0_valid && s0_item.op == trsc_pkg::FUNC_LOAD,
                (s0_item.sel < trsc_pkg::SEL_W'(trsc_pkg::ROTOR_COUNT))
                && ({1'b0, s0_item.idx} < ABC_LIMIT) && ({1'b0, s0_item.c} < ABC_LIMIT),
                "out-of-range load entered the pipe")
  `ASSERT_NEXT(a_step_one, clk, rst, cipher_beat && !restart,
               odo_state.off[0] == trsc_pkg::add_mod($past(odo_state.off[0]), 5'd1,
                                                     ALPHABET_SIZE),
               "rotor one did not step")
  `ASSERT_NEXT(a_carry_two, clk, rst,
               cipher_beat && !restart
               && odo_state.pos_lo == trsc_pkg::LETTER_W'(ALPHABET_SIZE - 1),
               odo_state.pos_lo == '0
               && odo_state.off[1] == trsc_pkg::add_mod($past(odo_state.off[1]), 5'd1,
                                                        ALPHABET_SIZE),
               "rotor two missed its carry")

endmodule
